// ----- hdl/aadd_pkg.sv -----
// Package with payload types, constants and the ordered double compare.
`default_nettype none
package aadd_pkg;

  localparam int unsigned IndexBitsDefault = 32;
  localparam int unsigned PosBits          = 32;
  localparam logic [63:0] SignBit          = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] elem_hi;
    logic [63:0] elem_lo;
    logic        is_last;
  } in_word_t;

  typedef struct packed {
    logic [PosBits-1:0] best_position;
    logic [63:0]        peak_hi;
    logic [63:0]        peak_lo;
  } out_word_t;

  function automatic logic is_nan(input logic [63:0] a);
    is_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] a);
    is_zero = (a[62:0] == 63'd0);
  endfunction

  // Ordered IEEE equality: NaN never equal, the two zeros equal.
  function automatic logic fp_eq(input logic [63:0] a, input logic [63:0] b);
    fp_eq = !is_nan(a) && !is_nan(b) && ((a == b) || (is_zero(a) && is_zero(b)));
  endfunction

  // Ordered IEEE greater-than on raw bit patterns.
  function automatic logic fp_gt(input logic [63:0] a, input logic [63:0] b);
    logic r;
    r = 1'b0;
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) begin
      r = 1'b0;
    end else if (!a[63] && b[63]) begin
      r = 1'b1;
    end else if (a[63] && !b[63]) begin
      r = 1'b0;
    end else if (!a[63]) begin
      r = (a[62:0] > b[62:0]);
    end else begin
      r = (a[62:0] < b[62:0]);
    end
    fp_gt = r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/aadd_mag_cmp.sv -----
// Magnitude forming and lexicographic compare against the held maximum.
`default_nettype none
module aadd_mag_cmp import aadd_pkg::*; (
  input  wire logic [63:0] elem_hi_i,
  input  wire logic [63:0] elem_lo_i,
  input  wire logic [63:0] peak_hi_i,
  input  wire logic [63:0] peak_lo_i,
  output logic      [63:0] mag_hi_o,
  output logic      [63:0] mag_lo_o,
  output logic             greater_o
);
  logic neg;

  // Numeric negative test: negative zero and NaN do not count.
  assign neg      = elem_hi_i[63] && !is_zero(elem_hi_i) && !is_nan(elem_hi_i);
  assign mag_hi_o = elem_hi_i & ~SignBit;
  assign mag_lo_o = neg ? (elem_lo_i ^ SignBit) : elem_lo_i;
  assign greater_o = fp_gt(mag_hi_o, peak_hi_i) ||
                     (fp_eq(mag_hi_o, peak_hi_i) && fp_gt(mag_lo_o, peak_lo_i));
endmodule
`default_nettype wire

// ----- hdl/argmax_abs_double_double.sv -----
// Top level: running argmax of double-double magnitude over a stream.
`default_nettype none
// One element is taken every cycle while the input is not stalled; the
// result word of a vector appears in the output register the cycle after
// its last element is taken. The single compare-and-update stage between
// input and held maximum sets this rate. While a result word waits in the
// output register and the receiver stalls, the input is stalled as well; a
// result taken in the same cycle makes room for the next one. Positions
// saturate at 2^INDEX_BITS - 1 and are reported in the low 32 bits.
module argmax_abs_double_double import aadd_pkg::*; #(
  parameter int unsigned INDEX_BITS = IndexBitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);
  localparam logic [INDEX_BITS-1:0] PosMax = '1;

  logic [63:0]           peak_hi_q, peak_lo_q, mag_hi, mag_lo;
  logic [INDEX_BITS-1:0] best_q, count_q, count_d;
  logic                  started_q, greater, take, accept, win;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q;
  logic [PosBits-1:0]    pos32;

  aadd_mag_cmp u_cmp (
    .elem_hi_i (in_word_i.elem_hi),
    .elem_lo_i (in_word_i.elem_lo),
    .peak_hi_i (peak_hi_q),
    .peak_lo_i (peak_lo_q),
    .mag_hi_o  (mag_hi),
    .mag_lo_o  (mag_lo),
    .greater_o (greater)
  );

  // Stall only when a result is waiting and the receiver stalls.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign count_d    = (count_q == PosMax) ? count_q : count_q + 1'b1;
  assign win        = !started_q || greater;
  assign take       = accept && win;
  assign pos32      = PosBits'(win ? count_d : best_q);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept && in_word_i.is_last) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      count_q     <= '0;
      best_q      <= '0;
      peak_hi_q   <= '0;
      peak_lo_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        if (in_word_i.is_last) begin
          started_q   <= 1'b0;
          count_q     <= '0;
          best_q      <= '0;
          peak_hi_q   <= '0;
          peak_lo_q   <= '0;
        end else begin
          started_q <= 1'b1;
          count_q   <= count_d;
          if (take) begin
            best_q    <= count_d;
            peak_hi_q <= mag_hi;
            peak_lo_q <= mag_lo;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_word_i.is_last) begin
      out_q.best_position <= pos32;
      out_q.peak_hi       <= win ? mag_hi : peak_hi_q;
      out_q.peak_lo       <= win ? mag_lo : peak_lo_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
endmodule
`default_nettype wire

// ----- hdl/aadd_checker.sv -----
// Port-level checker for the argmax block and its bind.
`default_nettype none
module aadd_checker import aadd_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_word_t  in_word_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);
  // A last word taken always yields a result word next cycle.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.is_last |=> out_valid_o)
    else $error("last word gave no result");

  // A non-last word with no waiting result gives no result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o && in_word_i.is_last) |=> !out_valid_o)
    else $error("result without last word");

  // Result positions are 1-based.
  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.best_position != '0)
    else $error("zero position");

  // Input is stalled only while a result is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stall without pending result");
endmodule

bind argmax_abs_double_double aadd_checker u_aadd_checker (.*);
`default_nettype wire

// ----- verif/argmax_abs_double_double_tb.sv -----
// Self-checking testbench for the double-double magnitude argmax block.
`timescale 1ns / 100ps
module argmax_abs_double_double_tb;
  import aadd_pkg::*;

  localparam logic [63:0] NegZero  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosInf   = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] QNan     = 64'h7ff8_0000_0000_0000;
  localparam logic [63:0] NegQNan  = 64'hfff8_0000_0000_0000;
  localparam logic [63:0] MaxFin   = 64'h7fef_ffff_ffff_ffff;
  localparam logic [63:0] MinSub   = 64'h0000_0000_0000_0001;
  localparam logic [63:0] OneDbl   = 64'h3ff0_0000_0000_0000;
  localparam logic [63:0] NegOne   = 64'hbff0_0000_0000_0000;
  localparam int unsigned CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // Running maximum kept by the predictor.
  logic [63:0] peak_hi_q, peak_lo_q;
  logic [31:0] best_pos_q, count_q;
  logic        started_q;
  out_word_t   expected_words[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  bit          failed = 1'b0;

  argmax_abs_double_double uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit dbl_nan(logic [63:0] a);
    return (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
  endfunction

  // Ordered greater-than done through the simulator's real type.
  function automatic bit dbl_gt(logic [63:0] a, logic [63:0] b);
    if (dbl_nan(a) || dbl_nan(b)) return 1'b0;
    return $bitstoreal(a) > $bitstoreal(b);
  endfunction

  function automatic bit dbl_eq(logic [63:0] a, logic [63:0] b);
    if (dbl_nan(a) || dbl_nan(b)) return 1'b0;
    return $bitstoreal(a) == $bitstoreal(b);
  endfunction

  task automatic track_peak(in_word_t w);
    logic [63:0] mh, ml;
    mh = {1'b0, w.elem_hi[62:0]};
    ml = w.elem_lo;
    if (dbl_gt(64'd0, w.elem_hi)) ml = w.elem_lo ^ SignBit;
    if (count_q != 32'hffff_ffff) count_q = count_q + 32'd1;
    if (!started_q || dbl_gt(mh, peak_hi_q) ||
        (dbl_eq(mh, peak_hi_q) && dbl_gt(ml, peak_lo_q))) begin
      peak_hi_q = mh;
      peak_lo_q = ml;
      best_pos_q = count_q;
      started_q = 1'b1;
    end
    if (w.is_last) begin
      expected_words.push_back('{best_position: best_pos_q, peak_hi: peak_hi_q,
                                 peak_lo: peak_lo_q});
      peak_hi_q = '0; peak_lo_q = '0; best_pos_q = '0; count_q = '0;
      started_q = 1'b0;
    end
  endtask

  // Valid stays high after a word is taken until the next call or the drain changes it.
  task automatic send_word(logic [63:0] hi, logic [63:0] lo, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= '{elem_hi: hi, elem_lo: lo, is_last: last};
    do @(posedge clk_i); while (in_stall_o);
    track_peak('{elem_hi: hi, elem_lo: lo, is_last: last});
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Half random bit patterns; the rest are zeros, NaNs, infinities and small-range values for ties.
  function automatic logic [63:0] rand_dbl();
    case ($urandom_range(9))
      0: return {1'($urandom_range(1)), 63'd0};
      1: return {1'($urandom_range(1)), 11'h7ff, 1'b1, 51'($urandom)};
      2: return {1'($urandom_range(1)), 11'h7ff, 52'd0};
      3: return {1'($urandom_range(1)), 61'd0, 2'($urandom)};
      4: return {1'($urandom_range(1)), 11'h3ff, 50'd0, 2'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    send_word(OneDbl, 64'd0, 1'b1);
    send_word(QNan, OneDbl, 1'b0);
    send_word(PosInf, 64'd0, 1'b1);
    send_word(NegZero, NegOne, 1'b0);
    send_word(64'd0, NegOne, 1'b0);
    send_word(64'd0, OneDbl, 1'b1);
    send_word(NegOne, OneDbl, 1'b0);
    send_word(OneDbl, NegOne, 1'b0);
    send_word(OneDbl, NegZero, 1'b1);
    send_word(MaxFin, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(64'hffff_ffff_ffff_ffff, MaxFin, 1'b0);
    send_word(NegQNan, QNan, 1'b0);
    send_word(PosInf, QNan, 1'b0);
    send_word(64'hfff0_0000_0000_0000, MinSub, 1'b1);
    send_word(MinSub, 64'd0, 1'b0);
    send_word(NegZero, PosInf, 1'b1);
    send_word(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1);
    send_word(64'd0, 64'd0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(int unsigned n_items, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n_items) send_word(rand_dbl(), rand_dbl(), $urandom_range(7) == 0);
    send_word(rand_dbl(), rand_dbl(), 1'b1);
    wait_drained();
  endtask

  // Receiver holds off while short vectors keep coming, so the block backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 200;
    repeat (40) send_word(rand_dbl(), rand_dbl(), 1'($urandom_range(1)));
    send_word(rand_dbl(), rand_dbl(), 1'b1);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", out_word_o);
        failed = 1'b1;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word_o.best_position !== exp_w.best_position) begin
          $error("best_position expected %0d got %0d", exp_w.best_position,
                 out_word_o.best_position);
          failed = 1'b1;
        end
        if (out_word_o.peak_hi !== exp_w.peak_hi) begin
          $error("peak_hi expected %h got %h", exp_w.peak_hi, out_word_o.peak_hi);
          failed = 1'b1;
        end
        if (out_word_o.peak_lo !== exp_w.peak_lo) begin
          $error("peak_lo expected %h got %h", exp_w.peak_lo, out_word_o.peak_lo);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    peak_hi_q = '0; peak_lo_q = '0; best_pos_q = '0; count_q = '0;
    started_q = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 70, 0);
    test_random(300, 0, 70);
    test_random(300, 9, 9);
    test_backpressure();
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
